FILE: sv/lobm_pkg.sv
package lobm_pkg;

	localparam int ORDER_SLOTS_DEF = 32;
	localparam int PRICE_BITS_DEF  = 16;
	localparam int QTY_BITS_DEF    = 16;

	localparam logic [20:0] VOL_MAX  = 21'h1FFFFF;
	localparam logic [15:0] ASK_NONE = 16'hFFFF;

	localparam logic [1:0] ACT_LIMIT  = 2'd0;
	localparam logic [1:0] ACT_MARKET = 2'd1;
	localparam logic [1:0] ACT_VOLUME = 2'd2;
	// unused code, answered as a volume query
	localparam logic [1:0] ACT_SPARE  = 2'd3;

	typedef enum logic [2:0] {
		K_TRADE  = 3'd0,
		K_RESTED = 3'd1,
		K_DONE   = 3'd2,
		K_BADQTY = 3'd3,
		K_FULL   = 3'd4,
		K_VOLUME = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_TRADE,
		ST_FINAL,
		ST_DRAIN_RD,
		ST_DRAIN_OUT
	} st_t;

	typedef struct packed {
		logic [1:0]  action;
		logic        side;
		logic [15:0] limit_price;
		logic [15:0] order_quantity;
		logic [15:0] trader_tag;
	} in_item_t;

	// one buffered result, best prices and last are attached on the way out
	typedef struct packed {
		kind_t       kind;
		logic [15:0] trade_price;
		logic [15:0] trade_quantity;
		logic [31:0] maker_order_id;
		logic [15:0] maker_trader;
		logic [15:0] maker_left;
		logic [15:0] taker_trader;
		logic [31:0] event_time;
		logic [20:0] level_volume;
	} res_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] trade_price;
		logic [15:0] trade_quantity;
		logic [31:0] maker_order_id;
		logic [15:0] maker_trader;
		logic [15:0] maker_left;
		logic [15:0] taker_trader;
		logic [31:0] event_time;
		logic [20:0] level_volume;
		logic [15:0] best_bid;
		logic [15:0] best_ask;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic scan_clr;
		logic scan_run;
		logic trade;
		logic fin;
		logic drain_load;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic trade_ok;
		logic out_free;
		logic drain_last;
	} sts_t;

endpackage

FILE: sv/lobm_chan_if.sv
interface lobm_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/lobm_ram.sv
module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/lobm_ctrl.sv
module lobm_ctrl import lobm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept   = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = sts.trade_ok ? ST_TRADE : ST_FINAL;
			end
			ST_TRADE: begin
				cmd.trade    = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_FINAL: begin
				cmd.fin = 1'b1;
				state_d = ST_DRAIN_RD;
			end
			ST_DRAIN_RD: begin
				state_d = ST_DRAIN_OUT;
			end
			ST_DRAIN_OUT: begin
				if (sts.out_free) begin
					cmd.drain_load = 1'b1;
					state_d        = sts.drain_last ? ST_IDLE : ST_DRAIN_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.scan_run, cmd.trade, cmd.fin, cmd.drain_load}))
		else $error("controller issued overlapping commands");
	a_trade_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trade |-> $past(state_q) == ST_DECIDE && $past(sts.trade_ok))
		else $error("trade without a positive decision");
	a_drain_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_load |-> sts.out_free)
		else $error("result load into a busy output register");
endmodule

FILE: sv/lobm_dp.sv
module lobm_dp import lobm_pkg::*; #(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
	parameter int PRICE_BITS  = PRICE_BITS_DEF,
	parameter int QTY_BITS    = QTY_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output sts_t      sts,
	input  in_item_t  in_item,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_item
);
	localparam int N  = ORDER_SLOTS;
	localparam int PW = PRICE_BITS;
	localparam int QW = QTY_BITS;
	localparam int IW = $clog2(N);
	localparam int CW = IW + 1;
	localparam int NW = $clog2(N + 1);
	localparam int XP = (PW > 16) ? PW : 16;
	localparam int XQ = (QW > 16) ? QW : 16;
	localparam int SW = ((QW > 21) ? QW : 21) + 1;

	typedef struct packed {
		logic          side;
		logic [PW-1:0] price;
		logic [QW-1:0] qty;
		logic [31:0]   oid;
		logic [15:0]   trader;
		logic [31:0]   arrival;
	} slot_t;

	// request registers
	logic [1:0]    act_q;
	logic          side_q;
	logic [PW-1:0] price_q;
	logic [QW-1:0] qty_q;
	logic [15:0]   tag_q;
	logic          bad_q;
	logic [31:0]   time_q;
	logic [31:0]   idc_q;
	logic [N-1:0]  valid_q;

	// scan results, index 0 bids, 1 asks
	logic [CW-1:0] sc_cnt_q;
	logic [1:0]    bhas_q;
	logic [IW-1:0] bidx_q [2];
	slot_t         brec_q [2];
	logic [31:0]   bage_q [2];
	logic          free_has_q;
	logic [IW-1:0] free_idx_q;
	logic [20:0]   vol_q;

	logic [NW-1:0] n_q;
	logic [NW-1:0] last_q;
	logic [NW-1:0] dr_q;
	logic [15:0]   bb_q;
	logic [15:0]   ba_q;
	logic          out_valid_q;
	out_item_t     out_q;

	// slot store
	slot_t         rd;
	logic          s_we;
	logic [IW-1:0] s_waddr;
	slot_t         s_wdata;
	logic [IW-1:0] s_raddr;

	// result buffer
	logic          r_we;
	res_t          r_wdata;
	res_t          r_rdata;

	// scan step
	logic [CW-1:0] jm;
	logic [IW-1:0] j;
	logic          proc;
	logic [31:0]   age;
	logic [1:0]    take;
	logic          vmatch;
	logic [SW-1:0] vsum;

	// trade and final
	logic          opp;
	slot_t         mrec;
	logic [QW-1:0] tq;
	logic [QW-1:0] newq;
	logic          price_ok;
	logic          is_order;
	logic          rest;
	logic [PW-1:0] bb_p;
	logic [PW-1:0] ba_p;
	logic          bb_has;
	logic          ba_has;
	logic [XP-1:0] xp_a;
	logic [XP-1:0] xp_b;
	logic [XP-1:0] xp_c;
	logic [XP-1:0] xp_d;
	logic [XQ-1:0] xq_a;
	logic [XQ-1:0] xq_b;
	logic [XQ-1:0] xq_c;

	assign jm   = sc_cnt_q - CW'(1);
	assign j    = jm[IW-1:0];
	assign proc = cmd.scan_run && (sc_cnt_q != '0);
	assign age  = time_q - rd.arrival;

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			take[s] = 1'b0;
			if (proc && valid_q[j] && (rd.side == s[0])) begin
				if (!bhas_q[s]) begin
					take[s] = 1'b1;
				end else if (rd.price != brec_q[s].price) begin
					take[s] = (s == 1) ? (rd.price < brec_q[s].price)
						: (rd.price > brec_q[s].price);
				end else begin
					take[s] = age > bage_q[s];
				end
			end
		end
	end

	assign vmatch = proc && valid_q[j] && (rd.side == side_q) && (rd.price == price_q);
	assign vsum   = SW'(vol_q) + SW'(rd.qty);

	assign opp      = ~side_q;
	assign mrec     = brec_q[opp];
	assign tq       = (qty_q < mrec.qty) ? qty_q : mrec.qty;
	assign newq     = mrec.qty - tq;
	assign is_order = (act_q == ACT_LIMIT) || (act_q == ACT_MARKET);
	assign price_ok = (act_q != ACT_LIMIT)
		|| (side_q ? (mrec.price >= price_q) : (mrec.price <= price_q));
	assign rest     = is_order && !bad_q && (act_q == ACT_LIMIT) && (qty_q != '0)
		&& free_has_q;

	// best prices after the step; a rested limit can only improve its own side
	always_comb begin
		bb_has = bhas_q[0];
		bb_p   = brec_q[0].price;
		ba_has = bhas_q[1];
		ba_p   = brec_q[1].price;
		if (rest && !side_q && (!bb_has || price_q > bb_p)) begin
			bb_has = 1'b1;
			bb_p   = price_q;
		end
		if (rest && side_q && (!ba_has || price_q < ba_p)) begin
			ba_has = 1'b1;
			ba_p   = price_q;
		end
	end

	assign xp_a = XP'(mrec.price);
	assign xp_b = XP'(price_q);
	assign xp_c = XP'(bb_p);
	assign xp_d = XP'(ba_p);
	assign xq_a = XQ'(tq);
	assign xq_b = XQ'(newq);
	assign xq_c = XQ'(qty_q);

	always_comb begin
		s_we    = 1'b0;
		s_waddr = free_idx_q;
		s_wdata = mrec;
		r_we    = cmd.trade || cmd.fin;
		r_wdata = '0;
		r_wdata.taker_trader = tag_q;
		r_wdata.event_time   = time_q;
		if (cmd.trade) begin
			s_we                   = 1'b1;
			s_waddr                = bidx_q[opp];
			s_wdata.qty            = newq;
			r_wdata.kind           = K_TRADE;
			r_wdata.trade_price    = xp_a[15:0];
			r_wdata.trade_quantity = xq_a[15:0];
			r_wdata.maker_order_id = mrec.oid;
			r_wdata.maker_trader   = mrec.trader;
			r_wdata.maker_left     = xq_b[15:0];
		end else if (!is_order) begin
			r_wdata.kind         = K_VOLUME;
			r_wdata.trade_price  = xp_b[15:0];
			r_wdata.taker_trader = '0;
			r_wdata.level_volume = vol_q;
		end else if (bad_q) begin
			r_wdata.kind = K_BADQTY;
		end else if (act_q == ACT_MARKET || qty_q == '0) begin
			r_wdata.kind = K_DONE;
		end else if (rest) begin
			s_we                   = cmd.fin;
			s_wdata.side           = side_q;
			s_wdata.price          = price_q;
			s_wdata.qty            = qty_q;
			s_wdata.oid            = idc_q;
			s_wdata.trader         = tag_q;
			s_wdata.arrival        = time_q;
			r_wdata.kind           = K_RESTED;
			r_wdata.trade_price    = xp_b[15:0];
			r_wdata.trade_quantity = xq_c[15:0];
			r_wdata.maker_order_id = idc_q;
			r_wdata.maker_trader   = tag_q;
			r_wdata.maker_left     = xq_c[15:0];
		end else begin
			r_wdata.kind           = K_FULL;
			r_wdata.trade_quantity = xq_c[15:0];
		end
	end

	assign s_raddr = (sc_cnt_q < CW'(N)) ? sc_cnt_q[IW-1:0] : '0;

	lobm_ram #(.WIDTH($bits(slot_t)), .DEPTH(N)) u_slots (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (rd)
	);

	lobm_ram #(.WIDTH($bits(res_t)), .DEPTH(N + 1)) u_results (
		.clk   (clk),
		.we    (r_we),
		.waddr (n_q),
		.wdata (r_wdata),
		.raddr (dr_q),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			time_q      <= '0;
			idc_q       <= '0;
			sc_cnt_q    <= '0;
			bhas_q      <= '0;
			free_has_q  <= 1'b0;
			n_q         <= '0;
			last_q      <= '0;
			dr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				n_q  <= '0;
				dr_q <= '0;
				if (in_item.action == ACT_LIMIT || in_item.action == ACT_MARKET) begin
					time_q <= time_q + 32'd1;
					if (in_item.order_quantity != '0) begin
						idc_q <= idc_q + 32'd1;
					end
				end
			end
			if (cmd.scan_clr) begin
				sc_cnt_q   <= '0;
				bhas_q     <= '0;
				free_has_q <= 1'b0;
			end else if (cmd.scan_run) begin
				sc_cnt_q <= sc_cnt_q + CW'(1);
				for (int s = 0; s < 2; s++) begin
					if (take[s]) begin
						bhas_q[s] <= 1'b1;
					end
				end
				if (proc && !valid_q[j] && !free_has_q) begin
					free_has_q <= 1'b1;
				end
			end
			if (cmd.trade) begin
				n_q <= n_q + NW'(1);
				if (newq == '0) begin
					valid_q[bidx_q[opp]] <= 1'b0;
				end
			end
			if (cmd.fin) begin
				last_q <= n_q;
				if (rest) begin
					valid_q[free_idx_q] <= 1'b1;
					idc_q               <= idc_q + 32'd1;
				end
			end
			if (cmd.drain_load) begin
				dr_q        <= dr_q + NW'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q   <= in_item.action;
			side_q  <= in_item.side;
			price_q <= PW'(in_item.limit_price);
			qty_q   <= QW'(in_item.order_quantity);
			tag_q   <= in_item.trader_tag;
			bad_q   <= (in_item.action == ACT_LIMIT || in_item.action == ACT_MARKET)
				&& (in_item.order_quantity == '0);
		end
		if (cmd.scan_clr) begin
			vol_q <= '0;
		end else if (cmd.scan_run) begin
			for (int s = 0; s < 2; s++) begin
				if (take[s]) begin
					bidx_q[s] <= j;
					brec_q[s] <= rd;
					bage_q[s] <= age;
				end
			end
			if (proc && !valid_q[j] && !free_has_q) begin
				free_idx_q <= j;
			end
			if (vmatch) begin
				vol_q <= (vsum > SW'(VOL_MAX)) ? VOL_MAX : vsum[20:0];
			end
		end
		if (cmd.trade) begin
			qty_q <= qty_q - tq;
		end
		if (cmd.fin) begin
			bb_q <= bb_has ? xp_c[15:0] : '0;
			ba_q <= ba_has ? xp_d[15:0] : ASK_NONE;
		end
		if (cmd.drain_load) begin
			out_q.kind           <= r_rdata.kind;
			out_q.trade_price    <= r_rdata.trade_price;
			out_q.trade_quantity <= r_rdata.trade_quantity;
			out_q.maker_order_id <= r_rdata.maker_order_id;
			out_q.maker_trader   <= r_rdata.maker_trader;
			out_q.maker_left     <= r_rdata.maker_left;
			out_q.taker_trader   <= r_rdata.taker_trader;
			out_q.event_time     <= r_rdata.event_time;
			out_q.level_volume   <= r_rdata.level_volume;
			out_q.best_bid       <= bb_q;
			out_q.best_ask       <= ba_q;
			out_q.last           <= (dr_q == last_q);
		end
	end

	// only looked at while scanning, the count is cleared on scan entry
	assign sts.scan_done  = (sc_cnt_q == CW'(N));
	assign sts.trade_ok   = is_order && !bad_q && (qty_q != '0) && (n_q < NW'(N))
		&& bhas_q[opp] && price_ok;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.drain_last = (dr_q == last_q);

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_trade_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trade |-> valid_q[bidx_q[opp]] && qty_q != '0 && tq != '0)
		else $error("trade against an empty slot or with nothing left");
	a_rest_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && rest |-> !valid_q[free_idx_q])
		else $error("remainder rested over a live order");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(N) && last_q <= NW'(N))
		else $error("result count beyond buffer depth");
	a_book_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trade && newq == '0 |=> !valid_q[$past(bidx_q[opp])])
		else $error("filled order left in the book");
endmodule

FILE: sv/limit_order_book_matcher.sv
// Price-time priority order book, one request at a time.
// Each trade takes a slot scan, a decide step and an update; the closing scan and
// status follow, then each result is read from the result buffer and loaded into the
// output register when it is free. Requests are handled one by one, the slot scan being
// serial because of the single read port of the slot store; a new request is taken
// while the last result waits.
// Reset: arst_n clears the book, time and id counters at once; no clearing pass.
module limit_order_book_matcher import lobm_pkg::*; #(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
	parameter int PRICE_BITS  = PRICE_BITS_DEF,
	parameter int QTY_BITS    = QTY_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lobm_chan_if.sink   orders,
	lobm_chan_if.source results
);
	cmd_t cmd;
	sts_t sts;

	lobm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (orders.valid),
		.in_ready (orders.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lobm_dp #(
		.ORDER_SLOTS (ORDER_SLOTS),
		.PRICE_BITS  (PRICE_BITS),
		.QTY_BITS    (QTY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (orders.payload),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.out_item  (results.payload)
	);
endmodule
